/* rtl/core/phd_pkg.sv */
package phd_pkg;

  localparam int PAD_COUNT_DEF = 8;

  // Field widths of the stream words
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int PADF_W   = 3;
  localparam int LEVEL_W  = 7;
  localparam int MS_W     = 10;
  localparam int PCT_W    = 7;
  localparam int WIN_W    = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 3;

  localparam int IN_W  = 104;
  localparam int OUT_W = 16;

  // Input word bit offsets, lowest field first
  localparam int OFS_PAD    = 0;
  localparam int OFS_SAMPLE = OFS_PAD + PADF_W;
  localparam int OFS_NOW    = OFS_SAMPLE + SAMPLE_W;
  localparam int OFS_TGT    = OFS_NOW + TIME_W;
  localparam int OFS_LEVEL  = OFS_TGT + PADF_W;
  localparam int OFS_THR    = OFS_LEVEL + LEVEL_W;
  localparam int OFS_SCAN   = OFS_THR + SAMPLE_W;
  localparam int OFS_LOCK   = OFS_SCAN + MS_W;
  localparam int OFS_MASK   = OFS_LOCK + MS_W;

  // Shared 12x7 multiplier and divide-by-100 through a reciprocal
  localparam int PROD_W      = SAMPLE_W + PCT_W;
  localparam int QUOT_W      = SAMPLE_W + 1;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

  localparam logic [TIME_W-1:0]  SCAN_MIN_MS   = 32'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;
  localparam logic [PCT_W-1:0]   ALLOWED_FLOOR = 7'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_XTALK  = 2'd1,
    CMD_PADSET = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window_ms;
    logic [PCT_W-1:0]    base_pct;
    logic [SAMPLE_W-1:0] min_fall;
    logic [PCT_W-1:0]    fall_pct;
    logic [PCT_W-1:0]    strong_pct;
    logic [SAMPLE_W-1:0] rest_level;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic mul;
    logic recip;
    logic decide;
    logic bleed;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic is_sample;
    logic end_scan;
    logic emit_blocked;
  } stat_t;

  function automatic logic [LEVEL_W-1:0] default_level(input logic [3:0] src,
                                                       input logic [3:0] tgt);
    logic [LEVEL_W-1:0] lv;
    case ({src, tgt})
      8'h02:   lv = 7'd15;
      8'h13:   lv = 7'd25;
      8'h34:   lv = 7'd35;
      8'h43:   lv = 7'd35;
      8'h53:   lv = 7'd30;
      8'h54:   lv = 7'd30;
      default: lv = '0;
    endcase
    return lv;
  endfunction

endpackage

/* rtl/core/pad_hit_detector_crosstalk_unit.sv */
// Drum pad hit detector with crosstalk rejection.
//
// Input stream (s_*): one word per item. s_tuser carries the command
// (sample, crosstalk level write, pad settings write); s_tdata carries the
// pad, sample, millisecond time and write operands.
// Output stream (m_*): one word per accepted hit, pad and peak.
// Config port (cfg_*): six registers, written at any edge with cfg_we high.
//
// The controller walks each word through read, multiply, reciprocal divide
// and decide steps around one shared 12x7 multiplier. A sample that ends a
// peak scan goes on through bleed and emit steps; a write command stops after
// read. The shared multiplier and the per-pad state read set these steps.
// A hit is registered into m_tvalid at the emit step.
//
// Reset clears the pad phases, the last-hit mark and the crosstalk
// overrides (defaults read back). Pad settings must be written before use.
// A stalled receiver holds the hit in the output register; new words are
// still taken; a second hit holds emit, and input, until the first is taken.
module pad_hit_detector_crosstalk_unit #(
  parameter int PAD_COUNT = phd_pkg::PAD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pad[2:0], sample[14:3], now_ms[46:15], target_pad[49:47], level[56:50],
  // threshold[68:57], scan_ms[78:69], lock_ms[88:79], mask_ms[98:89], zeros
  input  logic [phd_pkg::IN_W-1:0]      s_tdata,
  // cmd[1:0]
  input  logic [phd_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // hit_pad[2:0], hit_peak[14:3], zero[15]
  output logic [phd_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_we,
  input  logic [phd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [phd_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [phd_pkg::CFG_IDX_W-1:0] {
    REG_WINDOW = 3'd0,
    REG_BASE   = 3'd1,
    REG_MINFALL = 3'd2,
    REG_FALLPCT = 3'd3,
    REG_STRONG = 3'd4,
    REG_REST   = 3'd5
  } reg_idx_t;

  phd_pkg::cfg_t  cfg;
  phd_pkg::ctl_t  ctl;
  phd_pkg::stat_t stat;

  // Config registers; addresses past the list drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms  <= 8'd25;
      cfg.base_pct   <= 7'd45;
      cfg.min_fall   <= 12'd24;
      cfg.fall_pct   <= 7'd4;
      cfg.strong_pct <= 7'd65;
      cfg.rest_level <= 12'd40;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW:  cfg.window_ms  <= cfg_data[7:0];
        REG_BASE:    cfg.base_pct   <= cfg_data[6:0];
        REG_MINFALL: cfg.min_fall   <= cfg_data;
        REG_FALLPCT: cfg.fall_pct   <= cfg_data[6:0];
        REG_STRONG:  cfg.strong_pct <= cfg_data[6:0];
        REG_REST:    cfg.rest_level <= cfg_data;
        default: ;
      endcase
    end
  end

  phd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  phd_datapath #(
    .PAD_COUNT (PAD_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  // One word in flight: the word after acceptance is never taken at once
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while previous word in flight");

  // A hit appears only while a word is being worked on
  a_hit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("hit raised with no word in flight");

  // Output register empty after reset
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("hit valid after reset");
`endif

endmodule

/* rtl/core/phd_ctrl.sv */
module phd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  phd_pkg::stat_t stat,
  output phd_pkg::ctl_t  ctl
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_RECIP  = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_BLEED  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_READ;
      ST_READ:   state_next = stat.is_sample ? ST_MUL : ST_IDLE;
      ST_MUL:    state_next = ST_RECIP;
      ST_RECIP:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = stat.end_scan ? ST_BLEED : ST_IDLE;
      ST_BLEED:  state_next = ST_EMIT;
      ST_EMIT:   if (!stat.emit_blocked) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign s_tready    = (state == ST_IDLE);
  assign ctl.capture = (state == ST_IDLE) && s_tvalid;
  assign ctl.read    = (state == ST_READ);
  assign ctl.mul     = (state == ST_MUL);
  assign ctl.recip   = (state == ST_RECIP);
  assign ctl.decide  = (state == ST_DECIDE);
  assign ctl.bleed   = (state == ST_BLEED);
  assign ctl.emit    = (state == ST_EMIT);

endmodule

/* rtl/core/phd_datapath.sv */
module phd_datapath #(
  parameter int PAD_COUNT = phd_pkg::PAD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  phd_pkg::ctl_t               ctl,
  output phd_pkg::stat_t              stat,
  input  phd_pkg::cfg_t               cfg,
  input  logic [phd_pkg::IN_W-1:0]    s_tdata,
  input  logic [phd_pkg::CMD_W-1:0]   s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [phd_pkg::OUT_W-1:0]   m_tdata
);

  localparam int PW       = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int XA_W     = 2 * PW;
  localparam int XT_DEPTH = 1 << XA_W;
  localparam int SW       = phd_pkg::SAMPLE_W;
  localparam int TW       = phd_pkg::TIME_W;
  localparam int MW       = phd_pkg::MS_W;
  localparam int LW       = phd_pkg::LEVEL_W;
  localparam int QW       = phd_pkg::QUOT_W;
  localparam int PRW      = phd_pkg::PROD_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_LOCK = 2'd2,
    PH_MASK = 2'd3
  } phase_t;

  // Captured word
  logic [phd_pkg::CMD_W-1:0]  it_cmd;
  logic [phd_pkg::PADF_W-1:0] it_pad, it_tgt;
  logic [SW-1:0]              it_v, it_thr;
  logic [TW-1:0]              it_now;
  logic [LW-1:0]              it_level;
  logic [MW-1:0]              it_scan, it_lock, it_mask;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      it_cmd   <= s_tuser;
      it_pad   <= s_tdata[phd_pkg::OFS_PAD +: phd_pkg::PADF_W];
      it_v     <= s_tdata[phd_pkg::OFS_SAMPLE +: SW];
      it_now   <= s_tdata[phd_pkg::OFS_NOW +: TW];
      it_tgt   <= s_tdata[phd_pkg::OFS_TGT +: phd_pkg::PADF_W];
      it_level <= s_tdata[phd_pkg::OFS_LEVEL +: LW];
      it_thr   <= s_tdata[phd_pkg::OFS_THR +: SW];
      it_scan  <= s_tdata[phd_pkg::OFS_SCAN +: MW];
      it_lock  <= s_tdata[phd_pkg::OFS_LOCK +: MW];
      it_mask  <= s_tdata[phd_pkg::OFS_MASK +: MW];
    end
  end

  logic          pad_ok, tgt_ok;
  logic [PW-1:0] pidx, tidx;

  assign pad_ok = (32'(it_pad) < PAD_COUNT);
  assign tgt_ok = (32'(it_tgt) < PAD_COUNT);
  assign pidx   = PW'(it_pad);
  assign tidx   = PW'(it_tgt);
  assign stat.is_sample = pad_ok && (it_cmd == phd_pkg::CMD_SAMPLE);

  // Per-pad state and settings
  phase_t        phase  [PAD_COUNT];
  logic [SW-1:0] peak   [PAD_COUNT];
  logic [TW-1:0] timer  [PAD_COUNT];
  logic [SW-1:0] prev   [PAD_COUNT];
  logic [SW-1:0] lockpk [PAD_COUNT];
  logic [SW-1:0] thr_tb [PAD_COUNT];
  logic [MW-1:0] scan_tb[PAD_COUNT];
  logic [MW-1:0] lock_tb[PAD_COUNT];
  logic [MW-1:0] mask_tb[PAD_COUNT];

  // Last accepted hit
  logic          last_valid;
  logic [PW-1:0] last_pad;
  logic [SW-1:0] last_peak;
  logic [TW-1:0] last_time;

  always_ff @(posedge clk) begin
    if (ctl.read && pad_ok && (it_cmd == phd_pkg::CMD_PADSET)) begin
      thr_tb[pidx]  <= it_thr;
      scan_tb[pidx] <= it_scan;
      lock_tb[pidx] <= it_lock;
      mask_tb[pidx] <= it_mask;
    end
  end

  // Crosstalk levels, row = source pad; unwritten entries read their default
  logic [LW-1:0]   xt_mem  [XT_DEPTH];
  logic            xt_valid[XT_DEPTH];
  logic [XA_W-1:0] xt_waddr, xt_raddr;
  logic            xt_we;
  logic [LW-1:0]   xt_wdata, xt_rd, xt_def;
  logic            xt_rd_valid;
  logic [LW-1:0]   xt_level;

  assign xt_we    = ctl.read && pad_ok && tgt_ok && (it_cmd == phd_pkg::CMD_XTALK)
                    && (it_tgt != it_pad);
  assign xt_waddr = {pidx, tidx};
  assign xt_raddr = {last_pad, pidx};
  assign xt_wdata = (it_level > phd_pkg::LEVEL_MAX) ? phd_pkg::LEVEL_MAX : it_level;

  always_ff @(posedge clk) begin
    if (xt_we) begin
      xt_mem[xt_waddr] <= xt_wdata;
    end
    if (ctl.read) begin
      xt_rd <= xt_mem[xt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < XT_DEPTH; i++) begin
        xt_valid[i] <= 1'b0;
      end
      xt_rd_valid <= 1'b0;
    end else begin
      if (xt_we) begin
        xt_valid[xt_waddr] <= 1'b1;
      end
      if (ctl.read) begin
        xt_rd_valid <= xt_valid[xt_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read) begin
      xt_def <= phd_pkg::default_level(4'(last_pad), 4'(pidx));
    end
  end

  assign xt_level = xt_rd_valid ? xt_rd : xt_def;

  // Snapshot of the pad
  phase_t        r_phase;
  logic [SW-1:0] r_peak, r_prev, r_lockpk, r_thr;
  logic [TW-1:0] r_elapsed, r_hit_age;
  logic [MW-1:0] r_scan, r_lock, r_mask;

  always_ff @(posedge clk) begin
    if (ctl.read) begin
      r_phase   <= phase[pidx];
      r_peak    <= (it_v > peak[pidx]) ? it_v : peak[pidx];
      r_lockpk  <= (it_v > lockpk[pidx]) ? it_v : lockpk[pidx];
      r_prev    <= prev[pidx];
      r_thr     <= thr_tb[pidx];
      r_scan    <= scan_tb[pidx];
      r_lock    <= lock_tb[pidx];
      r_mask    <= mask_tb[pidx];
      r_elapsed <= it_now - timer[pidx];
      r_hit_age <= it_now - last_time;
    end
  end

  // Shared multiplier: fall or retrigger product, then bleed limit
  logic [PRW-1:0]             prod;
  logic [SW-1:0]              mul_a;
  logic [phd_pkg::PCT_W-1:0]  mul_b;
  logic signed [LW:0]         allowed_diff;
  logic [phd_pkg::PCT_W-1:0]  allowed;

  assign allowed_diff = $signed({1'b0, cfg.base_pct}) - $signed({1'b0, xt_level});
  assign allowed = (allowed_diff < $signed({1'b0, phd_pkg::ALLOWED_FLOOR}))
                   ? phd_pkg::ALLOWED_FLOOR : allowed_diff[LW-1:0];

  always_comb begin
    if (ctl.bleed) begin
      mul_a = last_peak;
      mul_b = allowed;
    end else if (r_phase == PH_SCAN) begin
      mul_a = r_peak;
      mul_b = cfg.fall_pct;
    end else begin
      mul_a = r_lockpk;
      mul_b = cfg.strong_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul || ctl.bleed) begin
      prod <= mul_a * mul_b;
    end
  end

  // Divide by 100 through a reciprocal
  logic [PRW+phd_pkg::RECIP_W-1:0] recip_full;
  logic [QW-1:0]                   quot;

  assign recip_full = prod * phd_pkg::RECIP_100;

  always_ff @(posedge clk) begin
    if (ctl.recip) begin
      quot <= QW'(recip_full >> phd_pkg::RECIP_SHIFT);
    end
  end

  // Phase decisions
  logic [QW-1:0] delta, lim;
  logic          prev_drop, peak_drop, falling, end_scan;
  logic          to_mask, retrig, start, mask_done;

  assign delta     = ({1'b0, cfg.min_fall} > quot) ? {1'b0, cfg.min_fall} : quot;
  assign prev_drop = (r_prev >= it_v) && ({1'b0, r_prev - it_v} >= delta);
  assign peak_drop = ({1'b0, r_peak - it_v} >= delta);
  assign falling   = (r_elapsed >= phd_pkg::SCAN_MIN_MS) && (prev_drop || peak_drop);
  assign end_scan  = (r_phase == PH_SCAN) && (falling || (r_elapsed >= TW'(r_scan)));

  assign lim       = ({1'b0, r_thr} > quot) ? {1'b0, r_thr} : quot;
  assign to_mask   = (r_elapsed >= TW'(r_lock)) || (it_v <= cfg.rest_level);
  assign retrig    = (it_v > r_thr) && ({1'b0, it_v} >= lim);
  assign start     = (it_v > r_thr);
  assign mask_done = (r_elapsed >= TW'(r_mask));

  assign stat.end_scan = end_scan;

  // Bleed test: peak*100/last_peak < allowed, written without a divide
  logic           bleed_pre, bleed;
  logic [PRW-1:0] peak100;

  always_ff @(posedge clk) begin
    if (ctl.bleed) begin
      bleed_pre <= last_valid && (last_pad != pidx) &&
                   (r_hit_age <= TW'(cfg.window_ms)) &&
                   (last_peak != '0) && (xt_level != '0);
    end
  end

  assign peak100 = PRW'(r_peak * 7'd100);
  assign bleed   = bleed_pre && (peak100 < prod);
  assign stat.emit_blocked = !bleed && m_tvalid && !m_tready;

  logic emit_go, hit_go;
  assign emit_go = ctl.emit && !stat.emit_blocked;
  assign hit_go  = emit_go && !bleed;

  // Pad state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        phase[i] <= PH_IDLE;
      end
    end else if (ctl.decide && !end_scan) begin
      unique case (r_phase)
        PH_IDLE: if (start) phase[pidx] <= PH_SCAN;
        PH_SCAN: ;
        PH_LOCK: begin
          if (to_mask) phase[pidx] <= PH_MASK;
          else if (retrig) phase[pidx] <= PH_SCAN;
        end
        PH_MASK: if (mask_done) phase[pidx] <= PH_IDLE;
        default: ;
      endcase
    end else if (emit_go) begin
      phase[pidx] <= (r_lock != '0) ? PH_LOCK : PH_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide && !end_scan) begin
      unique case (r_phase)
        PH_IDLE: begin
          if (start) begin
            peak[pidx]  <= it_v;
            prev[pidx]  <= it_v;
            timer[pidx] <= it_now;
          end
        end
        PH_SCAN: begin
          peak[pidx] <= r_peak;
          prev[pidx] <= it_v;
        end
        PH_LOCK: begin
          lockpk[pidx] <= r_lockpk;
          if (to_mask) begin
            timer[pidx] <= it_now;
            prev[pidx]  <= '0;
          end else if (retrig) begin
            peak[pidx]  <= it_v;
            prev[pidx]  <= it_v;
            timer[pidx] <= it_now;
          end
        end
        PH_MASK: begin
          if (mask_done) begin
            peak[pidx]   <= '0;
            prev[pidx]   <= '0;
            lockpk[pidx] <= '0;
          end
        end
        default: ;
      endcase
    end else if (emit_go) begin
      peak[pidx]   <= r_peak;
      prev[pidx]   <= '0;
      timer[pidx]  <= it_now;
      lockpk[pidx] <= r_peak;
    end
  end

  // Last hit and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (hit_go) begin
        last_valid <= 1'b1;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_go) begin
      last_pad  <= pidx;
      last_peak <= r_peak;
      last_time <= it_now;
      m_tdata   <= {1'b0, r_peak, phd_pkg::PADF_W'(pidx)};
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import phd_pkg::*;

  localparam int PADS        = 8;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 40;

  // pad machine phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_LOCK = 2'd2,
    PH_MASK = 2'd3
  } phase_t;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd5;

  // one input word, fields as in the stream
  typedef struct packed {
    logic [1:0]          cmd;
    logic [2:0]          pad;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
    logic [2:0]          tgt;
    logic [LEVEL_W-1:0]  level;
    logic [SAMPLE_W-1:0] thr;
    logic [MS_W-1:0]     scan_ms;
    logic [MS_W-1:0]     lock_ms;
    logic [MS_W-1:0]     mask_ms;
  } pad_word_t;

  typedef struct packed {
    logic [2:0]          pad;
    logic [SAMPLE_W-1:0] peak;
  } hit_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [CMD_W-1:0] s_tuser;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_data;

  pad_hit_detector_crosstalk_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_data
  );

  // predictor state
  int unsigned win_ms, base_pct, min_fall, fall_pct, strong_pct, rest_lvl;
  phase_t      ph      [PADS];
  int unsigned peak    [PADS];
  logic [31:0] tmr     [PADS];
  int unsigned prev    [PADS];
  int unsigned lpeak   [PADS];
  int unsigned thr_t   [PADS];
  int unsigned scan_t  [PADS];
  int unsigned lock_t  [PADS];
  int unsigned mask_t  [PADS];
  int unsigned xt      [PADS][PADS];
  bit          last_ok;
  int unsigned last_pad, last_peak;
  logic [31:0] last_t;

  pad_word_t   pending_words[$];
  hit_t        expected_hits[$];
  int          errors;
  int          idle_cycles;
  bit          send_hold;
  bit          stall_hold;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic bit bleed_check(int unsigned p, int unsigned pk, logic [31:0] now);
    int allowed;
    int unsigned ratio, lv;
    logic [31:0] d;
    d = now - last_t;
    if (!last_ok || p == last_pad) return 0;
    if (d > win_ms) return 0;
    if (last_peak == 0) return 0;
    lv = xt[last_pad][p];
    if (lv == 0) return 0;
    ratio = (pk * 100) / last_peak;
    allowed = int'(base_pct) - int'(lv);
    if (allowed < 5) allowed = 5;
    return int'(ratio) < allowed;
  endfunction

  function automatic void go_mask(int unsigned p, logic [31:0] now);
    tmr[p] = now;
    ph[p] = PH_MASK;
    prev[p] = 0;
  endfunction

  function automatic void go_scan(int unsigned p, int unsigned v, logic [31:0] now);
    peak[p] = v;
    tmr[p] = now;
    prev[p] = v;
    ph[p] = PH_SCAN;
  endfunction

  // advance the pad model by one word, queue the hit it causes
  function automatic void predict_hits(pad_word_t w);
    int unsigned p, v, lim, delta;
    logic [31:0] el;
    bit fall;
    p = w.pad;
    v = w.sample;
    case (w.cmd)
      CMD_XTALK: begin
        if (w.tgt != w.pad) xt[p][w.tgt] = (w.level > 100) ? 100 : w.level;
      end
      CMD_PADSET: begin
        thr_t[p] = w.thr;
        scan_t[p] = w.scan_ms;
        lock_t[p] = w.lock_ms;
        mask_t[p] = w.mask_ms;
      end
      CMD_SAMPLE: begin
        el = w.now_ms - tmr[p];
        case (ph[p])
          PH_IDLE: if (v > thr_t[p]) go_scan(p, v, w.now_ms);
          PH_SCAN: begin
            fall = 0;
            if (v > peak[p]) peak[p] = v;
            if (el >= 2) begin
              delta = (peak[p] * fall_pct) / 100;
              if (delta < min_fall) delta = min_fall;
              fall = (int'(prev[p]) - int'(v) >= int'(delta)) ||
                     (int'(peak[p]) - int'(v) >= int'(delta));
            end
            prev[p] = v;
            if (fall || el >= scan_t[p]) begin
              if (!bleed_check(p, peak[p], w.now_ms)) begin
                expected_hits.push_back('{pad: p[2:0], peak: peak[p][11:0]});
                last_ok = 1;
                last_pad = p;
                last_peak = peak[p];
                last_t = w.now_ms;
              end
              if (lock_t[p] > 0) begin
                tmr[p] = w.now_ms;
                ph[p] = PH_LOCK;
                lpeak[p] = peak[p];
              end else begin
                go_mask(p, w.now_ms);
              end
              prev[p] = 0;
            end
          end
          PH_LOCK: begin
            if (v > lpeak[p]) lpeak[p] = v;
            if (el >= lock_t[p] || v <= rest_lvl) begin
              go_mask(p, w.now_ms);
            end else if (v > thr_t[p]) begin
              lim = (lpeak[p] * strong_pct) / 100;
              if (lim < thr_t[p]) lim = thr_t[p];
              if (v >= lim) go_scan(p, v, w.now_ms);
            end
          end
          default: begin
            if (el >= mask_t[p]) begin
              peak[p] = 0;
              prev[p] = 0;
              lpeak[p] = 0;
              ph[p] = PH_IDLE;
            end
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  // driver: hold a word until taken, insert random gaps
  always @(negedge clk) begin
    pad_word_t w;
    if (!rst) begin
      if (s_tvalid && !s_tready) begin
        // hold
      end else if (pending_words.size() > 0 && !send_hold &&
                   ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0)) begin
        w = pending_words.pop_front();
        s_tuser <= w.cmd;
        s_tdata <= {5'd0, w.mask_ms, w.lock_ms, w.scan_ms, w.thr, w.level, w.tgt,
                    w.now_ms, w.sample, w.pad};
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 40) == 0) send_hold = 1;
      end else begin
        s_tvalid <= 1'b0;
        if (send_hold && $urandom_range(0, 30) == 0) send_hold = 0;
      end
      // receiver: mostly ready, short stalls, rare long ones
      if (stall_hold) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 25) == 0) stall_hold = 0;
      end else begin
        m_tready <= ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 60) == 0) stall_hold = 1;
      end
    end
  end

  // monitor: predict on accept, check hits
  always @(posedge clk) begin
    pad_word_t w;
    hit_t      h;
    if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (s_tvalid && s_tready) begin
        w.cmd = s_tuser;
        {w.mask_ms, w.lock_ms, w.scan_ms, w.thr, w.level, w.tgt, w.now_ms, w.sample,
         w.pad} = s_tdata[98:0];
        predict_hits(w);
        idle_cycles <= 0;
      end
      if (m_tvalid && m_tready) begin
        idle_cycles <= 0;
        if (expected_hits.size() == 0) begin
          report($sformatf("unexpected hit pad %0d peak %0d", m_tdata[2:0], m_tdata[14:3]));
        end else begin
          h = expected_hits.pop_front();
          if (m_tdata[2:0] != h.pad)
            report($sformatf("hit_pad %0d, want %0d", m_tdata[2:0], h.pad));
          if (m_tdata[14:3] != h.peak)
            report($sformatf("hit_peak %0d, want %0d", m_tdata[14:3], h.peak));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no traffic");
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW: win_ms = val & 8'hFF;
      REG_BASE:   base_pct = val & 7'h7F;
      REG_MINF:   min_fall = val & 12'hFFF;
      REG_FALLP:  fall_pct = val & 7'h7F;
      REG_STRONG: strong_pct = val & 7'h7F;
      default:    rest_lvl = val & 12'hFFF;
    endcase
  endtask

  // wait for the stream to go quiet before touching registers
  task automatic drain;
    while (pending_words.size() > 0 || s_tvalid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void push_word(logic [1:0] c, int unsigned p, int unsigned v,
                                    int unsigned dt);
    pad_word_t w;
    w = '0;
    clock_ms = clock_ms + dt;
    w.cmd = c;
    w.pad = p;
    w.sample = v;
    w.now_ms = clock_ms;
    w.tgt = $urandom;
    w.level = $urandom;
    w.thr = $urandom;
    w.scan_ms = $urandom;
    w.lock_ms = $urandom;
    w.mask_ms = $urandom;
    pending_words.push_back(w);
  endfunction

  function automatic void push_settings(int unsigned p, int unsigned th, int unsigned sc,
                                        int unsigned lk, int unsigned mk);
    pad_word_t w;
    w = '0;
    w.cmd = CMD_PADSET;
    w.pad = p;
    w.thr = th;
    w.scan_ms = sc;
    w.lock_ms = lk;
    w.mask_ms = mk;
    w.sample = $urandom;
    w.now_ms = $urandom;
    w.tgt = $urandom;
    w.level = $urandom;
    pending_words.push_back(w);
  endfunction

  function automatic void push_xtalk(int unsigned s, int unsigned t, int unsigned lv);
    pad_word_t w;
    w = '0;
    w.cmd = CMD_XTALK;
    w.pad = s;
    w.tgt = t;
    w.level = lv;
    w.now_ms = $urandom;
    w.sample = $urandom;
    pending_words.push_back(w);
  endfunction

  // one stroke: rise to a peak on a pad, then random tail samples, some on other pads, with random timing
  function automatic void push_stroke(int unsigned p);
    int unsigned pk, n, v;
    pk = $urandom_range(0, 9) == 0 ? 4095 : $urandom_range(60, 4000);
    n = $urandom_range(2, 8);
    for (int i = 1; i <= n; i++) begin
      v = (pk * i) / n;
      push_word(CMD_SAMPLE, p, v, $urandom_range(0, 1));
    end
    for (int i = 0; i < $urandom_range(2, 7); i++) begin
      v = (i == 0 && $urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, pk);
      push_word(CMD_SAMPLE, p, v, $urandom_range(0, 3));
      p = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : p;
    end
  endfunction

  initial begin
    int unsigned pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    send_hold = 0;
    stall_hold = 0;
    clock_ms = 32'hFFFF_FF00;   // wraps early in the run
    win_ms = 25; base_pct = 45; min_fall = 24; fall_pct = 4; strong_pct = 65;
    rest_lvl = 40;
    last_ok = 0; last_pad = 0; last_peak = 0; last_t = 0;
    for (int p = 0; p < PADS; p++) begin
      ph[p] = PH_IDLE; peak[p] = 0; tmr[p] = 0; prev[p] = 0; lpeak[p] = 0;
      thr_t[p] = 0; scan_t[p] = 0; lock_t[p] = 0; mask_t[p] = 0;
      for (int t = 0; t < PADS; t++) xt[p][t] = default_level(p, t);
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: settings for every pad, including zero lock and extremes
    push_settings(0, 100, 10, 0, 3);
    push_settings(1, 0, 0, 1023, 1023);
    for (int p = 2; p < PADS; p++) push_settings(p, 200, 8, 5, 4);
    push_xtalk(2, 2, 50);          // equal pads, dropped
    push_xtalk(0, 1, 127);         // clamped to the maximum
    push_xtalk(1, 0, 0);
    pending_words.push_back('{cmd: 2'd3, pad: 3'd7, sample: 12'hFFF, now_ms: '1,
                              tgt: '1, level: '1, thr: '1, scan_ms: '1, lock_ms: '1,
                              mask_ms: '1});
    push_word(CMD_SAMPLE, 0, 4095, 1);
    push_word(CMD_SAMPLE, 0, 4095, 2);
    push_word(CMD_SAMPLE, 0, 0, 1);     // fall ends scan, zero lock goes to mask
    push_word(CMD_SAMPLE, 2, 300, 0);   // bleed candidate from pad 0
    push_word(CMD_SAMPLE, 2, 310, 3);
    push_word(CMD_SAMPLE, 2, 0, 1);
    push_word(CMD_SAMPLE, 1, 1, 1);     // zero scan time ends at once
    push_word(CMD_SAMPLE, 1, 1, 1);
    push_word(CMD_SAMPLE, 1, 4095, 1);  // strong retrigger during lock
    push_word(CMD_SAMPLE, 1, 0, 2000);
    // pause until the block has caught up
    drain();

    for (int phase_n = 0; phase_n < 5; phase_n++) begin
      case (phase_n)
        0: begin
          write_reg(REG_WINDOW, 255); write_reg(REG_BASE, 100); write_reg(REG_MINF, 0);
          write_reg(REG_FALLP, 100); write_reg(REG_STRONG, 0); write_reg(REG_REST, 0);
        end
        1: begin
          write_reg(REG_WINDOW, 0); write_reg(REG_BASE, 0); write_reg(REG_MINF, 4095);
          write_reg(REG_FALLP, 0); write_reg(REG_STRONG, 100); write_reg(REG_REST, 4095);
        end
        2: begin
          write_reg(REG_WINDOW, 25); write_reg(REG_BASE, 45); write_reg(REG_MINF, 24);
          write_reg(REG_FALLP, 4); write_reg(REG_STRONG, 65); write_reg(REG_REST, 40);
        end
        default: begin
          write_reg(REG_WINDOW, $urandom_range(0, 255));
          write_reg(REG_BASE, $urandom_range(0, 100));
          write_reg(REG_MINF, $urandom_range(0, 300));
          write_reg(REG_FALLP, $urandom_range(0, 100));
          write_reg(REG_STRONG, $urandom_range(0, 100));
          write_reg(REG_REST, $urandom_range(0, 200));
        end
      endcase
      while (pending_words.size() < 250) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          push_settings($urandom_range(0, 7), $urandom_range(0, 9) == 0 ? 4095 :
                        $urandom_range(0, 400), $urandom_range(0, 12),
                        $urandom_range(0, 6), $urandom_range(0, 8));
        else if (pick == 1)
          push_xtalk($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 127));
        else if (pick == 2)
          push_word($urandom_range(0, 3), $urandom_range(0, 7), $urandom,
                    $urandom_range(0, 40));
        else
          push_stroke($urandom_range(0, 7));
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/phd_pkg.sv
rtl/core/phd_ctrl.sv
rtl/core/phd_datapath.sv
rtl/core/pad_hit_detector_crosstalk_unit.sv
bench/tb.sv
